// ===== rtl/cursor_file_header_parser_unit_assert.svh =====
// assertion macros for the cursor parser rtl
`ifndef CURSOR_FILE_HEADER_PARSER_UNIT_ASSERT_SVH
`define CURSOR_FILE_HEADER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define CFHP_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define CFHP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ===== rtl/cfhp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfhp_pkg
// types and constants shared by the cursor file header parser
// ----------------------------------------------------------------------------
package cfhp_pkg;

   // input word: one file byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [7:0]  pixel_byte;
      logic        last_pixel;
      logic [7:0]  image_width;
      logic [7:0]  image_height;
      logic [15:0] hotspot_x;
      logic [15:0] hotspot_y;
      logic [31:0] image_bytes;
      logic [31:0] data_offset;
   } rsp_word_type;

   // result of one parse step
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } parse_out_type;

   // result kinds
   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_RESERVED      = 3'd1;
   localparam logic [2:0] ERR_NOT_CURSOR    = 3'd2;
   localparam logic [2:0] ERR_NO_IMAGES     = 3'd3;
   localparam logic [2:0] ERR_DATA_OVERLAP  = 3'd4;

   // header layout
   localparam logic [31:0] POS_RESERVED = 32'd0;
   localparam logic [31:0] POS_TYPE     = 32'd2;
   localparam logic [31:0] POS_COUNT_LO = 32'd4;
   localparam logic [31:0] POS_COUNT_HI = 32'd5;
   localparam logic [7:0]  RESERVED_VALUE = 8'h00;
   localparam logic [7:0]  CURSOR_TYPE    = 8'h02;

   // directory entry layout
   localparam int unsigned ENTRY_LEN = 16;
   localparam logic [3:0]  IDX_WIDTH  = 4'd0;
   localparam logic [3:0]  IDX_HEIGHT = 4'd1;
   localparam logic [3:0]  IDX_LAST   = 4'(ENTRY_LEN - 1);

   // bitmap header plus mask skipped ahead of the pixel data
   localparam logic [32:0] PIXEL_SKIP = 33'(20 + 16 + 4);

   // parse phases
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_DIR    = 5'b00010,
      PH_SEEK   = 5'b00100,
      PH_PIX    = 5'b01000,
      PH_IDLE   = 5'b10000
   } phase_type;

endpackage

// ===== rtl/cfhp_parse.sv =====
// ----------------------------------------------------------------------------
// cfhp_parse
// parser state and per-byte decision logic
// ----------------------------------------------------------------------------
module cfhp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  cfhp_pkg::req_word_type word,
   output cfhp_pkg::parse_out_type result
);
   import cfhp_pkg::*;

   logic [31:0] pos_ff, pos_in, pos;
   phase_type   phase_ff, phase_in, phase;
   logic [15:0] image_count_ff, image_count_in;
   logic [15:0] entry_number_ff, entry_number_in;
   logic [3:0]  idx_ff, idx_in;
   logic [8:0]  best_sum_ff, best_sum_in;
   logic        entry_wins_ff, entry_wins_in;
   logic [7:0]  held_width_ff, held_width_in;
   logic [17:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  fields_ff [ENTRY_LEN];
   logic [7:0]  fields_in [ENTRY_LEN];

   logic [7:0]  b;
   logic [8:0]  sum;
   logic        wins;
   logic [7:0]  off_top;
   logic [31:0] off_final;
   logic [31:0] off_stored;
   logic [32:0] pix_start;
   logic [15:0] area;
   logic [17:0] pixels_dec;
   logic        pix_emit;

   always_comb begin
      b          = word.data_byte;
      pos        = word.first_byte ? 32'd0 : pos_ff;
      phase      = word.first_byte ? PH_HEADER : phase_ff;
      sum        = {1'b0, held_width_ff} + {1'b0, b};
      wins       = (entry_number_ff == 16'd0) || (sum > best_sum_ff);
      // last offset byte may be written by this very byte
      off_top    = entry_wins_ff ? b : fields_ff[15];
      off_final  = {off_top, fields_ff[14], fields_ff[13], fields_ff[12]};
      off_stored = {fields_ff[15], fields_ff[14], fields_ff[13], fields_ff[12]};
      pix_start  = {1'b0, off_stored} + PIXEL_SKIP;
      area       = {8'd0, fields_ff[0]} * {8'd0, fields_ff[1]};
      pixels_dec = pixels_left_ff - 18'd1;
      pix_emit   = 1'b0;

      pos_in          = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
      phase_in        = phase;
      image_count_in  = image_count_ff;
      entry_number_in = entry_number_ff;
      idx_in          = idx_ff;
      best_sum_in     = best_sum_ff;
      entry_wins_in   = entry_wins_ff;
      held_width_in   = held_width_ff;
      pixels_left_in  = pixels_left_ff;
      for (int k = 0; k < ENTRY_LEN; k++) begin
         fields_in[k] = fields_ff[k];
      end
      result = '0;

      case (phase)
         PH_HEADER: begin
            if (pos == POS_RESERVED && b != RESERVED_VALUE) begin
               result.valid           = 1'b1;
               result.word.kind       = KIND_ERROR;
               result.word.error_code = ERR_RESERVED;
               phase_in               = PH_IDLE;
            end else if (pos == POS_TYPE && b != CURSOR_TYPE) begin
               result.valid           = 1'b1;
               result.word.kind       = KIND_ERROR;
               result.word.error_code = ERR_NOT_CURSOR;
               phase_in               = PH_IDLE;
            end else if (pos == POS_COUNT_LO) begin
               image_count_in = {8'd0, b};
            end else if (pos == POS_COUNT_HI) begin
               image_count_in = {b, image_count_ff[7:0]};
               if ({b, image_count_ff[7:0]} == 16'd0) begin
                  result.valid           = 1'b1;
                  result.word.kind       = KIND_ERROR;
                  result.word.error_code = ERR_NO_IMAGES;
                  phase_in               = PH_IDLE;
               end else begin
                  phase_in        = PH_DIR;
                  entry_number_in = 16'd0;
                  idx_in          = 4'd0;
               end
            end
         end
         PH_DIR: begin
            if (idx_ff == IDX_WIDTH) begin
               held_width_in = b;
            end else if (idx_ff == IDX_HEIGHT) begin
               entry_wins_in = wins;
               if (wins) begin
                  best_sum_in  = sum;
                  fields_in[0] = held_width_ff;
                  fields_in[1] = b;
               end
            end else if (entry_wins_ff) begin
               fields_in[idx_ff] = b;
            end
            idx_in = idx_ff + 4'd1;
            if (idx_ff == IDX_LAST) begin
               entry_number_in = entry_number_ff + 16'd1;
               if (entry_number_in == image_count_ff) begin
                  result.valid = 1'b1;
                  if (off_final <= pos) begin
                     result.word.kind       = KIND_ERROR;
                     result.word.error_code = ERR_DATA_OVERLAP;
                     phase_in               = PH_IDLE;
                  end else begin
                     result.word.kind         = KIND_SUMMARY;
                     result.word.image_width  = fields_ff[0];
                     result.word.image_height = fields_ff[1];
                     result.word.hotspot_x    = {fields_ff[5], fields_ff[4]};
                     result.word.hotspot_y    = {fields_ff[7], fields_ff[6]};
                     result.word.image_bytes  = {fields_ff[11], fields_ff[10],
                                                 fields_ff[9], fields_ff[8]};
                     result.word.data_offset  = off_final;
                     pixels_left_in           = {area, 2'b00};
                     phase_in = (area == 16'd0) ? PH_IDLE : PH_SEEK;
                  end
               end
            end
         end
         PH_SEEK: begin
            if ({1'b0, pos} == pix_start) begin
               pix_emit = 1'b1;
            end
         end
         PH_PIX: begin
            pix_emit = 1'b1;
         end
         PH_IDLE: begin
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (pix_emit) begin
         pixels_left_in          = pixels_dec;
         result.valid            = 1'b1;
         result.word.kind        = KIND_PIXEL;
         result.word.pixel_byte  = b;
         result.word.last_pixel  = (pixels_dec == 18'd0);
         phase_in = (pixels_dec == 18'd0) ? PH_IDLE : PH_PIX;
      end

      // no word without a held byte being parsed
      if (!step) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         phase_ff        <= PH_HEADER;
         image_count_ff  <= '0;
         entry_number_ff <= '0;
         idx_ff          <= '0;
         best_sum_ff     <= '0;
         entry_wins_ff   <= 1'b0;
         held_width_ff   <= '0;
         pixels_left_ff  <= '0;
      end else if (step) begin
         pos_ff          <= pos_in;
         phase_ff        <= phase_in;
         image_count_ff  <= image_count_in;
         entry_number_ff <= entry_number_in;
         idx_ff          <= idx_in;
         best_sum_ff     <= best_sum_in;
         entry_wins_ff   <= entry_wins_in;
         held_width_ff   <= held_width_in;
         pixels_left_ff  <= pixels_left_in;
      end
   end

   // chosen entry bytes, no reset
   always_ff @(posedge clock) begin
      if (step) begin
         for (int k = 0; k < ENTRY_LEN; k++) begin
            fields_ff[k] <= fields_in[k];
         end
      end
   end

endmodule

// ===== rtl/cfhp_result_reg.sv =====
// ----------------------------------------------------------------------------
// cfhp_result_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
module cfhp_result_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  cfhp_pkg::parse_out_type result,
   input  logic                   rsp_stall,
   output logic                   room,
   output logic                   rsp_valid,
   output cfhp_pkg::rsp_word_type  rsp_word
);
   import cfhp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // register frees up when empty or when its word leaves this cycle
   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = room ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (room && result.valid) begin
         word_ff <= result.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/cursor_file_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// cursor_file_header_parser_unit
// parses a cursor file byte stream: header checks, largest directory entry,
// summary word, then the chosen image's pixel bytes
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid, req_stall | data_byte, first_byte
//  rsp     | out       | rsp_valid, rsp_stall | kind, error code, pixel, summary
//
//  one byte per cycle sustained unless rsp stalls; a byte is parsed while
//  held in the input register once the result register has room, and its
//  word is registered there for rsp; the parse step is one pass of compare
//  and latch logic per byte; synchronous reset clears control state only;
//  no clearing pass; rsp_stall holds the result register and, once the
//  input register is also full, raises req_stall
//
module cursor_file_header_parser_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cfhp_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cfhp_pkg::rsp_word_type  rsp_word
);
   import cfhp_pkg::*;

`include "cursor_file_header_parser_unit_assert.svh"

   // input register
   logic          in_valid_ff, in_valid_in;
   req_word_type  in_word_ff;

   // handshake between the stages
   logic          room;
   logic          step;
   parse_out_type result;

   // parse a held byte whenever the result register can take its word
   assign step      = in_valid_ff && room;
   // input register is busy only while its byte cannot move on
   assign req_stall = in_valid_ff && !room;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   // header, directory and pixel sequencing
   cfhp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (in_word_ff),
      .result (result)
   );

   // output side
   cfhp_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_stall (rsp_stall),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // a stall toward req only while a byte waits in the input register
   `CFHP_ASSERT_NOW(a_stall_needs_byte, clock, reset, req_stall, in_valid_ff, "stall with empty input register")

   // an error word always carries a code
   `CFHP_ASSERT_NOW(a_error_has_code, clock, reset, rsp_valid && rsp_word.kind == KIND_ERROR, rsp_word.error_code != ERR_NONE, "error word without code")

   // no word appears without a parsed byte behind it
   `CFHP_ASSERT_NEXT(a_no_phantom_word, clock, reset, room && !in_valid_ff, !rsp_valid, "result word without input byte")

endmodule
